/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* hdl/bef_pkg.sv */
// ----------------------------------------------------------------------------
// bef_pkg
// types and constants of the barcode end finder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bef_pkg;

    localparam int CODE_BITS       = 3;
    localparam int PATTERN_SYMBOLS = 31;
    localparam int LOW_SYMBOLS     = 16;
    localparam int LOW_WIDTH       = 48;
    localparam int HIGH_WIDTH      = 45;
    localparam int LEN_WIDTH       = 5;
    localparam int MIN_WIDTH       = 16;
    localparam int OUT_WIDTH       = 16;
    localparam int CFG_DATA_WIDTH  = 48;

    typedef logic [CODE_BITS-1:0] code_t;

    localparam code_t CODE_WILDCARD = 3'd4;
    localparam code_t CODE_NONE     = 3'd7;

    typedef enum logic [1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2,
        CFG_MIN_LENGTH     = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

/* hdl/barcode_end_finder_core.sv */
// ----------------------------------------------------------------------------
// barcode_end_finder_core
// shift-and exact barcode search over a read streamed one base per item
// ----------------------------------------------------------------------------
// Takes one base code per cycle (0=A 1=C 2=G 3=T 4=N) and runs the shift-and
// bit vector against the programmed barcode; a barcode N matches any base,
// a read N matches only barcode wildcards. The first full match end is kept,
// and the item flagged last yields one result: found, trim_start and
// read_length. Throughput is one item per clock. An item passes an input
// register, then a single update of the match vector and counters that also
// loads the result register, so a result is offered once its last item has
// left the input register. Input stalls only when a last item meets a result
// that is still waiting to be taken. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module barcode_end_finder_core
    import bef_pkg::*;
#(
    parameter int MAX_PATTERN = 31,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire cfg_index_t                cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [CODE_BITS-1:0]      symbol,
    input  wire logic                      last,

    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           found,
    output logic [OUT_WIDTH-1:0]           trim_start,
    output logic [OUT_WIDTH-1:0]           read_length
);

    localparam int M_WIDTH = 6;
    localparam int CMP_WIDTH = (COUNT_WIDTH > MIN_WIDTH) ? COUNT_WIDTH : MIN_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [LOW_WIDTH-1:0]  pattern_low_reg;
    logic [HIGH_WIDTH-1:0] pattern_high_reg;
    logic [LEN_WIDTH-1:0]  pattern_length_reg;
    logic [MIN_WIDTH-1:0]  min_length_reg;

    // input stage
    logic                  s1_valid_reg;
    code_t                 s1_symbol_reg;
    logic                  s1_last_reg;
    logic                  s1_advance;

    // per-read state
    logic [MAX_PATTERN-1:0] match_vector_reg;
    logic [MAX_PATTERN-1:0] match_vector_next;
    logic [COUNT_WIDTH-1:0] symbol_count_reg;
    logic [COUNT_WIDTH-1:0] symbol_count_next;
    logic                   match_seen_reg;
    logic                   match_seen_next;
    logic [COUNT_WIDTH-1:0] match_end_reg;
    logic [COUNT_WIDTH-1:0] match_end_next;

    // result register
    logic                 out_valid_reg;
    logic                 found_reg;
    logic [OUT_WIDTH-1:0] trim_start_reg;
    logic [OUT_WIDTH-1:0] read_length_reg;

    logic [LOW_WIDTH+HIGH_WIDTH-1:0] pattern_all;
    logic [LEN_WIDTH-1:0]   eff_length;
    logic [MAX_PATTERN-1:0] symbol_hits;
    logic [MAX_PATTERN-1:0] length_mask;
    logic [MAX_PATTERN-1:0] top_select;
    logic                   full_match;
    logic [CMP_WIDTH-1:0]   remaining;
    logic                   found_next;
    logic [CMP_WIDTH-1:0]   count_ext;
    logic [CMP_WIDTH-1:0]   end_ext;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= LEN_WIDTH'(1);
            min_length_reg     <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data[LOW_WIDTH-1:0];
                CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data[HIGH_WIDTH-1:0];
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[LEN_WIDTH-1:0];
                CFG_MIN_LENGTH:     min_length_reg     <= cfg_data[MIN_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // handshake
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_symbol_reg <= symbol;
            s1_last_reg   <= last;
        end
    end

    // barcode length capped at the vector size
    assign eff_length = ({1'b0, pattern_length_reg} > M_WIDTH'(MAX_PATTERN))
                        ? LEN_WIDTH'(MAX_PATTERN) : pattern_length_reg;

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    // per-position compare against the current base
    for (genvar i = 0; i < MAX_PATTERN; i++)
    begin : g_pos
        code_t code;
        if (i < PATTERN_SYMBOLS)
        begin : g_stored
            assign code = pattern_all[CODE_BITS*i +: CODE_BITS];
        end
        else
        begin : g_beyond
            assign code = CODE_NONE;
        end
        assign symbol_hits[i] = (code == CODE_WILDCARD)
                              || ((code < CODE_WILDCARD) && (s1_symbol_reg < CODE_WILDCARD)
                                  && (code == s1_symbol_reg));
        assign length_mask[i] = M_WIDTH'(i) < {1'b0, eff_length};
        assign top_select[i]  = (M_WIDTH'(i) + M_WIDTH'(1)) == {1'b0, eff_length};
    end

    always_comb
    begin
        symbol_count_next = (symbol_count_reg == COUNT_MAX)
                            ? symbol_count_reg : symbol_count_reg + COUNT_WIDTH'(1);
        match_vector_next = {match_vector_reg[MAX_PATTERN-2:0], 1'b1}
                            & symbol_hits & length_mask;
        full_match        = |(match_vector_next & top_select);
        match_seen_next   = match_seen_reg;
        match_end_next    = match_end_reg;
        if (!match_seen_reg && full_match)
        begin
            match_seen_next = 1'b1;
            match_end_next  = symbol_count_next;
        end
        count_ext  = CMP_WIDTH'(symbol_count_next);
        end_ext    = CMP_WIDTH'(match_end_next);
        remaining  = count_ext - end_ext;
        found_next = match_seen_next && (remaining >= CMP_WIDTH'(min_length_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_vector_reg <= '0;
            symbol_count_reg <= '0;
            match_seen_reg   <= 1'b0;
            match_end_reg    <= '0;
        end
        else if (s1_advance)
        begin
            if (s1_last_reg)
            begin
                match_vector_reg <= '0;
                symbol_count_reg <= '0;
                match_seen_reg   <= 1'b0;
                match_end_reg    <= '0;
            end
            else
            begin
                match_vector_reg <= match_vector_next;
                symbol_count_reg <= symbol_count_next;
                match_seen_reg   <= match_seen_next;
                match_end_reg    <= match_end_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            found_reg       <= found_next;
            trim_start_reg  <= found_next ? end_ext[OUT_WIDTH-1:0] : '0;
            read_length_reg <= (count_ext > CMP_WIDTH'({OUT_WIDTH{1'b1}}))
                               ? {OUT_WIDTH{1'b1}} : count_ext[OUT_WIDTH-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign trim_start  = trim_start_reg;
    assign read_length = read_length_reg;

`include "assert_macros.svh"

    `ASSERT_IMPLY(a_result_from_last, $rose(out_valid_reg), $past(s1_advance && s1_last_reg), "result without a last item")
    `ASSERT_IMPLY(a_clear_after_last, $past(s1_advance && s1_last_reg), (symbol_count_reg == '0) && !match_seen_reg, "read state not cleared after last item")
    `ASSERT_IMPLY(a_match_end_set, match_seen_reg, match_end_reg != '0, "latched match end is zero")
    `ASSERT_CLK(a_stage_free, s1_valid_reg || in_ready, "input stalled with empty stage")

endmodule

`default_nettype wire
